// ===== sv/ejenc_pkg.sv =====
package ejenc_pkg;

	localparam int MAX_RES = 7;

	// One input word: an EUC-JP byte or a flush marker.
	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_input;
	} in_word_t;

	// One output word: a 7-bit JIS byte or a status report.
	typedef struct packed {
		logic [6:0] out_byte;
		logic [1:0] status;
		logic       last;
	} out_word_t;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_ILLEGAL    = 2'd1;
	localparam logic [1:0] ST_INCOMPLETE = 2'd2;

	typedef enum logic [1:0] {
		SH_ROMAN = 2'd0,
		SH_X0208 = 2'd1,
		SH_KANA  = 2'd2,
		SH_X0212 = 2'd3
	} shift_t;

	typedef enum logic [2:0] {
		PD_NONE    = 3'd0,
		PD_LEAD    = 3'd1,
		PD_SS2     = 3'd2,
		PD_SS3     = 3'd3,
		PD_SS3_2ND = 3'd4
	} pend_t;

	// Emit command handed from the front end to the back end: the whole byte
	// sequence that one input word causes, with its length and status.
	typedef struct packed {
		logic [2:0]                    len;
		logic [1:0]                    status;
		logic [MAX_RES-1:0][6:0]       bytes;
	} cmd_t;

	localparam logic [6:0] CH_ESC    = 7'h1B;
	localparam logic [6:0] CH_SO     = 7'h0E;
	localparam logic [6:0] CH_SI     = 7'h0F;
	localparam logic [6:0] CH_LPAREN = 7'h28;
	localparam logic [6:0] CH_DOLLAR = 7'h24;
	localparam logic [6:0] CH_J      = 7'h4A;
	localparam logic [6:0] CH_B      = 7'h42;
	localparam logic [6:0] CH_D      = 7'h44;

	localparam logic [7:0] EUC_SS2 = 8'h8E;
	localparam logic [7:0] EUC_SS3 = 8'h8F;

endpackage

// ===== sv/ejenc_front.sv =====
module ejenc_front
	import ejenc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_word_t in_word,
	input  logic     q_full,
	output logic     cmd_push,
	output cmd_t     cmd
);

	shift_t     shift_q, shift_d;
	pend_t      pend_q, pend_d;
	logic [7:0] held_q, held_d;
	logic       take;

	function automatic logic is_dbl(input logic [7:0] c);
		return (c >= 8'hA1) && (c <= 8'hFE);
	endfunction

	function automatic logic is_kana(input logic [7:0] c);
		return (c >= 8'hA1) && (c <= 8'hDF);
	endfunction

	assign in_ready = !q_full;
	assign take     = in_valid && in_ready;

	always_comb begin
		logic       f_esc_j, f_si, f_so, f_esc_b, f_esc_d, f_err;
		logic [1:0] dlen;
		logic [6:0] d0, d1;
		logic [1:0] err_st;
		logic [2:0] n;
		logic [7:0] c;

		c       = in_word.in_byte;
		f_esc_j = 1'b0;
		f_si    = 1'b0;
		f_so    = 1'b0;
		f_esc_b = 1'b0;
		f_esc_d = 1'b0;
		f_err   = 1'b0;
		err_st  = ST_ILLEGAL;
		dlen    = 2'd0;
		d0      = c[6:0];
		d1      = c[6:0];
		shift_d = shift_q;
		pend_d  = pend_q;
		held_d  = held_q;

		if (in_word.end_of_input) begin
			if (pend_q != PD_NONE) begin
				pend_d = PD_NONE;
				f_err  = 1'b1;
				err_st = ST_INCOMPLETE;
			end else if (shift_q == SH_X0208 || shift_q == SH_X0212) begin
				f_esc_j = 1'b1;
				shift_d = SH_ROMAN;
			end else if (shift_q == SH_KANA) begin
				f_si    = 1'b1;
				shift_d = SH_ROMAN;
			end
		end else begin
			case (pend_q)
				PD_NONE: begin
					if (!c[7]) begin
						f_esc_j = (shift_q == SH_X0208 || shift_q == SH_X0212);
						f_si    = (shift_q == SH_KANA);
						shift_d = SH_ROMAN;
						dlen    = 2'd1;
					end else if (is_dbl(c)) begin
						pend_d = PD_LEAD;
						held_d = c;
					end else if (c == EUC_SS2) begin
						pend_d = PD_SS2;
					end else if (c == EUC_SS3) begin
						pend_d = PD_SS3;
					end else begin
						f_err = 1'b1;
					end
				end
				PD_LEAD: begin
					pend_d = PD_NONE;
					if (is_dbl(c)) begin
						f_si    = (shift_q == SH_KANA);
						f_esc_b = (shift_q != SH_X0208);
						shift_d = SH_X0208;
						dlen    = 2'd2;
						d0      = held_q[6:0];
					end else begin
						f_err = 1'b1;
					end
				end
				PD_SS2: begin
					pend_d = PD_NONE;
					if (is_kana(c)) begin
						f_esc_j = (shift_q == SH_X0208 || shift_q == SH_X0212);
						f_so    = (shift_q != SH_KANA);
						shift_d = SH_KANA;
						dlen    = 2'd1;
					end else begin
						f_err = 1'b1;
					end
				end
				PD_SS3: begin
					pend_d = PD_SS3_2ND;
					held_d = c;
				end
				PD_SS3_2ND: begin
					pend_d = PD_NONE;
					if (is_dbl(held_q) && is_dbl(c)) begin
						f_si    = (shift_q == SH_KANA);
						f_esc_d = (shift_q != SH_X0212);
						shift_d = SH_X0212;
						dlen    = 2'd2;
						d0      = held_q[6:0];
					end else begin
						f_err = 1'b1;
					end
				end
				default: begin
					pend_d = PD_NONE;
					f_err  = 1'b1;
				end
			endcase
		end

		// Assemble the byte sequence: a leave sequence first, then an enter
		// sequence, then the code bytes. Never more than seven in all.
		cmd.bytes  = '0;
		cmd.status = ST_OK;
		n          = 3'd0;
		if (f_err) begin
			cmd.status = err_st;
			n          = 3'd1;
		end else begin
			if (f_si) begin
				cmd.bytes[n] = CH_SI;
				n = n + 3'd1;
			end
			if (f_esc_j) begin
				cmd.bytes[n] = CH_ESC;
				n = n + 3'd1;
				cmd.bytes[n] = CH_LPAREN;
				n = n + 3'd1;
				cmd.bytes[n] = CH_J;
				n = n + 3'd1;
			end
			if (f_so) begin
				cmd.bytes[n] = CH_SO;
				n = n + 3'd1;
			end
			if (f_esc_b) begin
				cmd.bytes[n] = CH_ESC;
				n = n + 3'd1;
				cmd.bytes[n] = CH_DOLLAR;
				n = n + 3'd1;
				cmd.bytes[n] = CH_B;
				n = n + 3'd1;
			end
			if (f_esc_d) begin
				cmd.bytes[n] = CH_ESC;
				n = n + 3'd1;
				cmd.bytes[n] = CH_DOLLAR;
				n = n + 3'd1;
				cmd.bytes[n] = CH_LPAREN;
				n = n + 3'd1;
				cmd.bytes[n] = CH_D;
				n = n + 3'd1;
			end
			if (dlen != 2'd0) begin
				cmd.bytes[n] = d0;
				n = n + 3'd1;
			end
			if (dlen == 2'd2) begin
				cmd.bytes[n] = d1;
				n = n + 3'd1;
			end
		end
		cmd.len  = n;
		cmd_push = take && (n != 3'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= SH_ROMAN;
			pend_q  <= PD_NONE;
			held_q  <= '0;
		end else if (take) begin
			shift_q <= shift_d;
			pend_q  <= pend_d;
			held_q  <= held_d;
		end
	end

endmodule

// ===== sv/ejenc_queue.sv =====
module ejenc_queue
	import ejenc_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	output logic head_valid,
	output cmd_t head_cmd,
	input  logic pop
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_cmd   = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== sv/ejenc_back.sv =====
module ejenc_back
	import ejenc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      head_valid,
	input  cmd_t      head_cmd,
	output logic      pop,
	output logic      out_valid,
	input  logic      out_ready,
	output out_word_t out_word
);

	logic [2:0] idx_q;
	logic       out_valid_q;
	out_word_t  out_q;
	logic       load;
	logic       at_end;

	assign load   = head_valid && (!out_valid_q || out_ready);
	assign at_end = (idx_q == head_cmd.len - 3'd1);
	assign pop    = load && at_end;

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= at_end ? 3'd0 : idx_q + 3'd1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.out_byte <= head_cmd.bytes[idx_q];
			out_q.status   <= head_cmd.status;
			out_q.last     <= at_end;
		end
	end

endmodule

// ===== sv/eucjp_to_iso2022jp_encoder.sv =====
// EUC-JP to ISO-2022-JP converter.
// Input channel (in_valid, in_ready, in_word): one EUC-JP byte per word, or a
// flush word with end_of_input set. Output channel (out_valid, out_ready,
// out_word): one 7-bit JIS byte or one status report per word; last marks the
// final word caused by an input word. Words that cause nothing (a lead byte,
// SS2, SS3, a flush in the Roman set) give no output at all.
// The front end tracks the shift state and the partly collected character and
// turns each input word into an emit command of one to seven bytes. Commands
// wait in a small queue (QUEUE_DEPTH entries); the back end plays them out one
// byte per cycle, while out_ready is high, through a registered output stage.
// An accepted input word's emit command is registered in the queue, and its
// output words in the output stage. Throughput: one input word per cycle while
// the queue has room; the output side moves one word per cycle while out_ready
// is high, so an item that adds a designation (up to five extra bytes) holds
// the output longer, and the input stalls only once the queue fills.
// Reset puts the stream in the Roman set with nothing pending and the queue
// empty. When the receiver drops out_ready the output word is held, the
// queue fills, and in_ready falls; nothing is lost.
module eucjp_to_iso2022jp_encoder
	import ejenc_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_word_t  in_word,
	output logic      out_valid,
	input  logic      out_ready,
	output out_word_t out_word
);

	// Front end to queue.
	logic cmd_push;
	cmd_t cmd;
	logic q_full;

	// Queue to back end.
	logic head_valid;
	cmd_t head_cmd;
	logic pop;

	ejenc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_word  (in_word),
		.q_full   (q_full),
		.cmd_push (cmd_push),
		.cmd      (cmd)
	);

	ejenc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (cmd_push),
		.push_cmd   (cmd),
		.full       (q_full),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop)
	);

	ejenc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_word   (out_word)
	);

endmodule

// ===== verif/tb_eucjp_to_iso2022jp_encoder.sv =====
`timescale 1ns / 100ps

// Self-checking bench for the EUC-JP to ISO-2022-JP converter.
// A queue of input words is filled up front: a short directed run through
// character set changes and error cases, then random traffic that is
// mostly well-formed characters with a share of noise and broken sequences.
// The driver plays the queue into the block with random gaps. Each accepted
// word is fed to a behavioral copy of the converter, which appends the JIS
// words it should cause to a queue of expected words. The monitor stalls
// out_ready at random and checks every word that comes out against the
// oldest expectation.
module tb_eucjp_to_iso2022jp_encoder;
	import ejenc_pkg::*;

	localparam int RANDOM_WORDS = 400;
	// The limit leaves plenty of room over the slowest correct run.
	localparam int CYCLE_LIMIT = 200000;
	// Extra wait after the last expected word, to catch stray output.
	localparam int DRAIN_CYCLES = 16;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_word_t  in_word = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_word_t out_word;

	// Words waiting to be sent, and JIS words the block still owes us.
	in_word_t  euc_pending[$];
	out_word_t jis_expect[$];

	int stim_count = 0;
	int words_taken = 0;
	int fault_count = 0;
	int cycle_count = 0;
	int send_gap = 0;
	int recv_stall = 0;
	int stall_draw;
	bit steady_in = 1'b0;
	bit steady_out = 1'b0;

	// Behavioral copy of the converter state.
	shift_t     jis_shift = SH_ROMAN;
	pend_t      euc_pend = PD_NONE;
	logic [7:0] euc_held = '0;

	eucjp_to_iso2022jp_encoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word)
	);

	always #5 clk = ~clk;

	// The run is stopped here if the block hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("eucjp_to_iso2022jp_encoder: mismatch");
			$finish;
		end
	end

	// Bytes that can be either half of a JIS X 0208 or JIS X 0212 character.
	function automatic bit is_row_byte(logic [7:0] b);
		return b >= 8'hA1 && b <= 8'hFE;
	endfunction

	// Bytes that can follow SS2 as a half-width kana.
	function automatic bit is_kana_byte(logic [7:0] b);
		return b >= 8'hA1 && b <= 8'hDF;
	endfunction

	function automatic void emit(logic [6:0] code, logic [1:0] st);
		out_word_t w;
		w.out_byte = code;
		w.status = st;
		w.last = 1'b0;
		jis_expect.push_back(w);
	endfunction

	function automatic void emit_roman_escape();
		emit(CH_ESC, ST_OK);
		emit(CH_LPAREN, ST_OK);
		emit(CH_J, ST_OK);
	endfunction

	// Works out what one accepted input word must produce and advances the
	// shift state and the partly collected character. The final word of the
	// group is marked with last.
	task automatic convert_word(input in_word_t w);
		int         base_count;
		logic [7:0] b;
		logic [7:0] kept;
		out_word_t  tail;
		base_count = jis_expect.size();
		b = w.in_byte;
		kept = euc_held;
		if (w.end_of_input) begin
			// A flush drops any fragment; otherwise it returns to Roman.
			if (euc_pend != PD_NONE) begin
				euc_pend = PD_NONE;
				euc_held = '0;
				emit('0, ST_INCOMPLETE);
			end else if (jis_shift == SH_X0208 || jis_shift == SH_X0212) begin
				emit_roman_escape();
				jis_shift = SH_ROMAN;
			end else if (jis_shift == SH_KANA) begin
				emit(CH_SI, ST_OK);
				jis_shift = SH_ROMAN;
			end
		end else begin
			case (euc_pend)
				PD_NONE: begin
					if (b <= 8'h7F) begin
						if (jis_shift == SH_X0208 || jis_shift == SH_X0212)
							emit_roman_escape();
						else if (jis_shift == SH_KANA)
							emit(CH_SI, ST_OK);
						jis_shift = SH_ROMAN;
						emit(b[6:0], ST_OK);
					end else if (is_row_byte(b)) begin
						euc_pend = PD_LEAD;
						euc_held = b;
					end else if (b == EUC_SS2) begin
						euc_pend = PD_SS2;
					end else if (b == EUC_SS3) begin
						euc_pend = PD_SS3;
					end else begin
						emit('0, ST_ILLEGAL);
					end
				end
				PD_LEAD: begin
					euc_pend = PD_NONE;
					euc_held = '0;
					if (is_row_byte(b)) begin
						if (jis_shift == SH_KANA) begin
							emit(CH_SI, ST_OK);
							jis_shift = SH_ROMAN;
						end
						if (jis_shift != SH_X0208) begin
							emit(CH_ESC, ST_OK);
							emit(CH_DOLLAR, ST_OK);
							emit(CH_B, ST_OK);
							jis_shift = SH_X0208;
						end
						emit(kept[6:0], ST_OK);
						emit(b[6:0], ST_OK);
					end else begin
						emit('0, ST_ILLEGAL);
					end
				end
				PD_SS2: begin
					euc_pend = PD_NONE;
					euc_held = '0;
					if (is_kana_byte(b)) begin
						if (jis_shift == SH_X0208 || jis_shift == SH_X0212) begin
							emit_roman_escape();
							jis_shift = SH_ROMAN;
						end
						if (jis_shift != SH_KANA) begin
							emit(CH_SO, ST_OK);
							jis_shift = SH_KANA;
						end
						emit(b[6:0], ST_OK);
					end else begin
						emit('0, ST_ILLEGAL);
					end
				end
				PD_SS3: begin
					// Both trailing bytes are collected before any check.
					euc_pend = PD_SS3_2ND;
					euc_held = b;
				end
				PD_SS3_2ND: begin
					euc_pend = PD_NONE;
					euc_held = '0;
					if (is_row_byte(kept) && is_row_byte(b)) begin
						if (jis_shift == SH_KANA) begin
							emit(CH_SI, ST_OK);
							jis_shift = SH_ROMAN;
						end
						if (jis_shift != SH_X0212) begin
							emit(CH_ESC, ST_OK);
							emit(CH_DOLLAR, ST_OK);
							emit(CH_LPAREN, ST_OK);
							emit(CH_D, ST_OK);
							jis_shift = SH_X0212;
						end
						emit(kept[6:0], ST_OK);
						emit(b[6:0], ST_OK);
					end else begin
						emit('0, ST_ILLEGAL);
					end
				end
				default: begin
					euc_pend = PD_NONE;
					euc_held = '0;
					emit('0, ST_ILLEGAL);
				end
			endcase
		end
		if (jis_expect.size() > base_count) begin
			tail = jis_expect.pop_back();
			tail.last = 1'b1;
			jis_expect.push_back(tail);
		end
	endtask

	function automatic void push_byte(logic [7:0] b);
		in_word_t w;
		w.in_byte = b;
		w.end_of_input = 1'b0;
		euc_pending.push_back(w);
		stim_count++;
	endfunction

	// The byte field of a flush word is ignored, so it carries noise.
	function automatic void push_flush();
		in_word_t w;
		w.in_byte = 8'($urandom_range(0, 255));
		w.end_of_input = 1'b1;
		euc_pending.push_back(w);
		stim_count++;
	endfunction

	// Sends a trailing byte, or now and then cuts the character short with
	// a flush.
	function automatic void push_trail_or_flush(logic [7:0] b);
		if ($urandom_range(0, 5) == 0)
			push_flush();
		else
			push_byte(b);
	endfunction

	// Driver. A word is offered as soon as its gap has run out, and held
	// until the block takes it. The gap before the next word is drawn when
	// a word is offered, and long stretches run with no gaps at all.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_word <= '0;
			send_gap <= 0;
		end else begin
			if (in_valid && in_ready) begin
				convert_word(in_word);
				words_taken++;
			end
			if (!in_valid || in_ready) begin
				if (send_gap != 0) begin
					in_valid <= 1'b0;
					send_gap <= send_gap - 1;
				end else if (euc_pending.size() != 0) begin
					in_word <= euc_pending.pop_front();
					in_valid <= 1'b1;
					if ($urandom_range(0, 47) == 0)
						steady_in <= !steady_in;
					send_gap <= steady_in ? 0 : $urandom_range(0, 4);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor. Every word taken from the block is checked field by field
	// against the oldest expectation; after each one, out_ready drops for a
	// random number of cycles.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_stall <= 0;
		end else if (out_valid && out_ready) begin
			if (jis_expect.size() == 0) begin
				$error("out_word: expected nothing, actual %h", out_word);
				fault_count++;
			end else begin
				if (out_word.out_byte !== jis_expect[0].out_byte) begin
					$error("out_byte: expected %h, actual %h",
						jis_expect[0].out_byte, out_word.out_byte);
					fault_count++;
				end
				if (out_word.status !== jis_expect[0].status) begin
					$error("status: expected %0d, actual %0d",
						jis_expect[0].status, out_word.status);
					fault_count++;
				end
				if (out_word.last !== jis_expect[0].last) begin
					$error("last: expected %b, actual %b",
						jis_expect[0].last, out_word.last);
					fault_count++;
				end
				void'(jis_expect.pop_front());
			end
			if ($urandom_range(0, 47) == 0)
				steady_out <= !steady_out;
			stall_draw = steady_out ? 0 : $urandom_range(0, 4);
			out_ready <= (stall_draw == 0);
			recv_stall <= (stall_draw == 0) ? 0 : stall_draw - 1;
		end else if (recv_stall != 0) begin
			out_ready <= 1'b0;
			recv_stall <= recv_stall - 1;
		end else begin
			out_ready <= 1'b1;
		end
	end

	initial begin
		int         kind;
		int         first_count;
		logic [7:0] lead;

		// Directed part, starting from the Roman set after reset.
		push_byte(8'h00);
		push_byte(8'h7F);
		// JIS X 0208 character: ESC $ B, then the two bytes.
		push_byte(8'hA1);
		push_byte(8'hFE);
		// A second one needs no designation.
		push_byte(8'hFE);
		push_byte(8'hA1);
		// Kana from JIS X 0208: ESC ( J, SO and the byte, five words.
		push_byte(EUC_SS2);
		push_byte(8'hA1);
		push_byte(EUC_SS2);
		push_byte(8'hDF);
		// JIS X 0212 from kana: SI, then ESC $ ( D.
		push_byte(EUC_SS3);
		push_byte(8'hA1);
		push_byte(8'hFE);
		// Flush in JIS X 0212, then a flush in Roman that gives nothing.
		push_flush();
		push_flush();
		// Illegal trailing bytes after SS2 and after a lead byte.
		push_byte(EUC_SS2);
		push_byte(8'hE0);
		push_byte(8'hA1);
		push_byte(8'h20);
		// Illegal first bytes.
		push_byte(8'h80);
		push_byte(8'hFF);
		// SS3 with a bad second byte; the error waits for the third byte.
		push_byte(EUC_SS3);
		push_byte(8'hA0);
		push_byte(8'hA1);
		// Flush with a lead byte held.
		push_byte(8'hFE);
		push_flush();
		// Kana then ASCII: SI in front of the byte.
		push_byte(EUC_SS2);
		push_byte(8'hA1);
		push_byte(8'h41);

		// Random part: mostly whole characters of every set, plus noise,
		// broken sequences and flushes.
		first_count = stim_count;
		while (stim_count - first_count < RANDOM_WORDS) begin
			kind = $urandom_range(0, 99);
			if (kind < 20) begin
				push_byte(8'($urandom_range(0, 127)));
			end else if (kind < 38) begin
				push_byte(8'($urandom_range(8'hA1, 8'hFE)));
				push_byte(8'($urandom_range(8'hA1, 8'hFE)));
			end else if (kind < 52) begin
				push_byte(EUC_SS2);
				push_byte(8'($urandom_range(8'hA1, 8'hDF)));
			end else if (kind < 66) begin
				push_byte(EUC_SS3);
				push_byte(8'($urandom_range(8'hA1, 8'hFE)));
				push_byte(8'($urandom_range(8'hA1, 8'hFE)));
			end else if (kind < 74) begin
				push_flush();
			end else if (kind < 82) begin
				push_byte(8'($urandom_range(0, 255)));
			end else if (kind < 88) begin
				lead = 8'($urandom_range(8'hA1, 8'hFE));
				push_byte(lead);
				push_trail_or_flush(8'($urandom_range(0, 255)));
			end else if (kind < 93) begin
				push_byte(EUC_SS2);
				push_trail_or_flush(8'($urandom_range(0, 255)));
			end else begin
				push_byte(EUC_SS3);
				push_trail_or_flush(8'($urandom_range(0, 255)));
				// The third byte only follows if the second one was sent.
				if (euc_pending[$].end_of_input == 1'b0)
					push_trail_or_flush(8'($urandom_range(0, 255)));
			end
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Wait for every word to be taken, then for every expected word to
		// come out, then a little longer to catch stray output.
		while (words_taken < stim_count)
			@(posedge clk);
		while (jis_expect.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fault_count == 0)
			$display("eucjp_to_iso2022jp_encoder: match");
		else
			$display("eucjp_to_iso2022jp_encoder: mismatch");
		$finish;
	end

endmodule
